// File: design/bgms_pkg.sv
// Shared constants and types for the binary grid majority smoother.
// No dependencies; imported by the top level.
package bgms_pkg;

	localparam int MAP_ROWS    = 32;
	localparam int MAP_COLUMNS = 64;

	localparam int ROW_W   = 5;
	localparam int COL_W   = 6;
	localparam int COUNT_W = 4;
	localparam int THR_W   = 4;

	localparam logic [THR_W-1:0] WALL_THRESHOLD_RESET = THR_W'(5);

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAP_ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAP_COLUMNS - 1);

	typedef logic [1:0] op_t;
	localparam op_t OP_WRITE  = 2'd0;
	localparam op_t OP_READ   = 2'd1;
	localparam op_t OP_SMOOTH = 2'd2;

	typedef logic [MAP_COLUMNS-1:0] row_word_t;

endpackage

// File: design/binary_grid_majority_smoother.sv
// Binary tile map with write, read and in-place 3x3 majority smoothing.
// Depends on bgms_pkg and bgms_ram.
//
// Usage: the map (32 rows x 64 columns, 1 = wall) lives in one RAM, one row
// word per entry, and reads as all empty after reset without any clearing
// pass (per-row valid bits). Every request reads rows r-1, r and r+1 through
// the RAM's single read port and then reaches write-back, where a write or an
// interior smooth writes row r back and the result is registered. A new
// request waits until then: the next request is taken in the write-back
// cycle; a read of the row being written is forwarded. A result waits in an
// output register; write-back stalls while it is full and m_tready is low.
// The user writes wall_threshold on the cfg channel while idle (not enforced).
module binary_grid_majority_smoother (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [4:0] row_index, [10:5] column_index, [11] tile_in
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] tile_out, [4:1] neighbour_walls
	output logic        m_tuser,   // [0] border_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data   // wall_threshold
);

	import bgms_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MID,
		ST_LOW,
		ST_CALC
	} state_t;

	state_t               state_q;
	logic [THR_W-1:0]     thr_q;
	logic [MAP_ROWS-1:0]  row_valid_q;
	logic                 out_valid_q;
	logic                 fwd_q;
	row_word_t            fwd_word_q;

	op_t                  op_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic                 tin_q;
	row_word_t            above_q;
	row_word_t            mid_q;
	logic [ROW_W-1:0]     rd_addr_q;

	logic                 out_tile_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic                 out_err_q;

	logic                 accept;
	logic                 out_free;
	logic                 finish;
	logic [ROW_W-1:0]     s_row;
	logic                 ram_re;
	logic [ROW_W-1:0]     ram_raddr;
	row_word_t            ram_rdata;
	row_word_t            rd_word;
	logic                 ram_we;

	logic                 in_map;
	logic                 border;
	logic                 cur_tile;
	logic [2:0]           win_above;
	logic [2:0]           win_mid;
	logic [2:0]           win_below;
	logic [COUNT_W-1:0]   count;
	logic                 res_tile;
	logic [COUNT_W-1:0]   res_count;
	logic                 res_err;
	logic                 res_write;
	row_word_t            new_word;
	row_word_t            shift_above;
	row_word_t            shift_mid;
	row_word_t            shift_below;

	assign s_row     = s_tdata[ROW_W-1:0];
	assign out_free  = !out_valid_q || m_tready;
	assign finish    = (state_q == ST_CALC) && out_free;
	assign s_tready  = (state_q == ST_IDLE) || finish;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// read sequencer: row above, own row, row below
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = s_row - 1'b1;
		case (state_q)
			ST_IDLE, ST_CALC: begin
				ram_re    = accept;
				ram_raddr = s_row - 1'b1;
			end
			ST_MID: begin
				ram_re    = 1'b1;
				ram_raddr = row_q;
			end
			ST_LOW: begin
				ram_re    = 1'b1;
				ram_raddr = row_q + 1'b1;
			end
			default: begin
				ram_re    = 1'b0;
				ram_raddr = s_row - 1'b1;
			end
		endcase
	end

	// never-written rows read as empty
	assign rd_word = fwd_q ? fwd_word_q :
		(row_valid_q[rd_addr_q] ? ram_rdata : '0);

	assign in_map   = (int'(row_q) < MAP_ROWS) && (int'(col_q) < MAP_COLUMNS);
	assign border   = !in_map || (row_q == '0) || (col_q == '0) ||
		(row_q == ROW_LAST) || (col_q == COL_LAST);
	assign cur_tile = in_map ? mid_q[col_q] : 1'b0;

	// window columns c-1..c+1; only used for interior cells
	assign shift_above = above_q >> (col_q - 1'b1);
	assign shift_mid   = mid_q >> (col_q - 1'b1);
	assign shift_below = rd_word >> (col_q - 1'b1);
	assign win_above   = shift_above[2:0];
	assign win_mid     = shift_mid[2:0];
	assign win_below   = shift_below[2:0];

	assign count = COUNT_W'(win_above[0]) + COUNT_W'(win_above[1]) + COUNT_W'(win_above[2])
		+ COUNT_W'(win_mid[0]) + COUNT_W'(win_mid[1]) + COUNT_W'(win_mid[2])
		+ COUNT_W'(win_below[0]) + COUNT_W'(win_below[1]) + COUNT_W'(win_below[2]);

	always_comb begin
		res_tile  = 1'b0;
		res_count = '0;
		res_err   = 1'b0;
		res_write = 1'b0;
		new_word  = mid_q;
		case (op_q)
			OP_WRITE: begin
				res_write       = in_map;
				res_tile        = in_map ? tin_q : 1'b0;
				new_word[col_q] = tin_q;
			end
			OP_READ: begin
				res_tile = cur_tile;
			end
			OP_SMOOTH: begin
				if (border) begin
					res_err  = 1'b1;
					res_tile = cur_tile;
				end else begin
					res_count       = count;
					res_tile        = (count >= thr_q);
					res_write       = 1'b1;
					new_word[col_q] = (count >= thr_q);
				end
			end
			default: begin
				res_tile = 1'b0;
			end
		endcase
	end

	assign ram_we = finish && res_write;

	bgms_ram #(
		.WIDTH (MAP_COLUMNS),
		.DEPTH (MAP_ROWS)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q),
		.wdata (new_word),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= WALL_THRESHOLD_RESET;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (ram_we) begin
				row_valid_q[row_q] <= 1'b1;
			end
			fwd_q <= ram_we && accept && (ram_raddr == row_q);
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MID;
					end
				end
				ST_MID: begin
					state_q <= ST_LOW;
				end
				ST_LOW: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (finish) begin
						state_q <= accept ? ST_MID : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			row_q <= s_row;
			col_q <= s_tdata[ROW_W+COL_W-1:ROW_W];
			tin_q <= s_tdata[ROW_W+COL_W];
		end
		if (ram_re) begin
			rd_addr_q <= ram_raddr;
		end
		fwd_word_q <= new_word;
		if (state_q == ST_MID) begin
			above_q <= rd_word;
		end
		if (state_q == ST_LOW) begin
			mid_q <= rd_word;
		end
		if (finish) begin
			out_tile_q  <= res_tile;
			out_count_q <= res_count;
			out_err_q   <= res_err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_count_q, out_tile_q};
	assign m_tuser  = out_err_q;

	a_write_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CALC))
		else $error("map write outside write-back");

	a_accept_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MID))
		else $error("accepted request did not start row reads");

	a_finish_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> m_tvalid)
		else $error("finished request produced no result");

	a_fwd_only_mid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> (state_q == ST_MID))
		else $error("forwarded word outside first read");

	a_error_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[4:1] == '0))
		else $error("refused smooth reported a wall count");

endmodule

// File: design/bgms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bgms_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
